FILE: src/tmaa_pkg.sv
// Shared types, constants and the multiply schedule of the mesh area accumulator.
`default_nettype none

package tmaa_pkg;

  // Widths of the result fields and of the running state.
  localparam int unsigned SUM_W   = 63;
  localparam int unsigned COUNT_W = 32;
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Multiply schedule: six cross-product terms, then three partial products per square.
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned NUM_STEPS = 15;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);
  localparam logic [STEP_W-1:0] STEP_END  = STEP_W'(NUM_STEPS);

  // Edge register indexes: e1 = v1 - v0, e2 = v2 - v0.
  localparam logic [2:0] E1X = 3'd0;
  localparam logic [2:0] E1Y = 3'd1;
  localparam logic [2:0] E1Z = 3'd2;
  localparam logic [2:0] E2X = 3'd3;
  localparam logic [2:0] E2Y = 3'd4;
  localparam logic [2:0] E2Z = 3'd5;

  // Cross product axes.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Partial product kinds of a square split into high and low halves.
  localparam logic [1:0] KIND_HH = 2'd0;
  localparam logic [1:0] KIND_HL = 2'd1;
  localparam logic [1:0] KIND_LL = 2'd2;

  // Decoded view of one multiply step.
  typedef struct packed {
    logic       is_cross;
    logic       odd;
    logic [1:0] axis;
    logic [1:0] kind;
    logic [2:0] op_a;
    logic [2:0] op_b;
  } step_info_t;

  // Handshake between the sequencer and the square-root unit.
  typedef struct packed {
    logic start;
  } sqrt_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

  // Operands and destination of each multiply step.
  function automatic step_info_t step_info(input logic [STEP_W-1:0] step);
    step_info_t si;
    si = '0;
    case (step)
      4'd0: begin
        si.is_cross = 1'b1; si.axis = AXIS_X; si.op_a = E1Y; si.op_b = E2Z;
      end
      4'd1: begin
        si.is_cross = 1'b1; si.odd = 1'b1; si.axis = AXIS_X; si.op_a = E1Z; si.op_b = E2Y;
      end
      4'd2: begin
        si.is_cross = 1'b1; si.axis = AXIS_Y; si.op_a = E1Z; si.op_b = E2X;
      end
      4'd3: begin
        si.is_cross = 1'b1; si.odd = 1'b1; si.axis = AXIS_Y; si.op_a = E1X; si.op_b = E2Z;
      end
      4'd4: begin
        si.is_cross = 1'b1; si.axis = AXIS_Z; si.op_a = E1X; si.op_b = E2Y;
      end
      4'd5: begin
        si.is_cross = 1'b1; si.odd = 1'b1; si.axis = AXIS_Z; si.op_a = E1Y; si.op_b = E2X;
      end
      4'd6:  begin si.axis = AXIS_X; si.kind = KIND_HH; end
      4'd7:  begin si.axis = AXIS_X; si.kind = KIND_HL; end
      4'd8:  begin si.axis = AXIS_X; si.kind = KIND_LL; end
      4'd9:  begin si.axis = AXIS_Y; si.kind = KIND_HH; end
      4'd10: begin si.axis = AXIS_Y; si.kind = KIND_HL; end
      4'd11: begin si.axis = AXIS_Y; si.kind = KIND_LL; end
      4'd12: begin si.axis = AXIS_Z; si.kind = KIND_HH; end
      4'd13: begin si.axis = AXIS_Z; si.kind = KIND_HL; end
      4'd14: begin si.axis = AXIS_Z; si.kind = KIND_LL; end
      default: si = '0;
    endcase
    return si;
  endfunction

endpackage

`default_nettype wire

FILE: src/triangle_mesh_area_accumulator.sv
// Top level: per-triangle doubled area by cross product and square root, summed per mesh.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i, in_stall_o   v0_x_i .. v2_z_i, last_face_i
//   out      output     out_valid_o, out_stall_i total_area_o, saturated_o, face_count_o
//
// One triangle occupies the block from acceptance through the shared multiplier
// (six cross-product terms, nine partial squares), the bit-serial square root and the
// accumulate state; no new triangle is taken before the current one is through.
// in_stall_o is high from acceptance until the sum is updated.
// A last face waits in the accumulate cycle while a previous total is still stalled.
// Reset clears the running sum, the flag, the face count and the output valid.
`default_nettype none

module triangle_mesh_area_accumulator
  import tmaa_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 24
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic [COORD_WIDTH-1:0]  v0_x_i,
  input  wire logic [COORD_WIDTH-1:0]  v0_y_i,
  input  wire logic [COORD_WIDTH-1:0]  v0_z_i,
  input  wire logic [COORD_WIDTH-1:0]  v1_x_i,
  input  wire logic [COORD_WIDTH-1:0]  v1_y_i,
  input  wire logic [COORD_WIDTH-1:0]  v1_z_i,
  input  wire logic [COORD_WIDTH-1:0]  v2_x_i,
  input  wire logic [COORD_WIDTH-1:0]  v2_y_i,
  input  wire logic [COORD_WIDTH-1:0]  v2_z_i,
  input  wire logic                    last_face_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [SUM_W-1:0]             total_area_o,
  output logic                         saturated_o,
  output logic [COUNT_W-1:0]           face_count_o
);

  localparam int unsigned W    = COORD_WIDTH;
  localparam int unsigned H    = W + 1;         // multiplier operand width
  localparam int unsigned RW   = 2 * H;         // cross term and root width
  localparam int unsigned LW   = 4 * H;         // squared length width
  localparam int unsigned AW   = ((RW > SUM_W) ? RW : SUM_W) + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_RGO   = 3'd2;
  localparam logic [2:0] ST_RWAIT = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [STEP_W-1:0]   step_q;
  logic [STEP_W-1:0]   pstep_q;
  logic                pvld_q;
  logic                abs_pend_q;
  logic [1:0]          abs_axis_q;

  logic [W-1:0]        e_mag_q [6];
  logic                e_neg_q [6];
  logic [W-1:0]        e_mag_d [6];
  logic                e_neg_d [6];
  logic [W:0]          e_diff  [6];
  logic [W-1:0]        c0 [3];
  logic [W-1:0]        c1 [3];
  logic [W-1:0]        c2 [3];

  logic [2*H-1:0]      prod_q;
  logic                pneg_q;
  logic [RW-1:0]       cacc_q;
  logic [RW-1:0]       cm_q [3];
  logic [LW-1:0]       len_q;
  logic                last_q;

  logic [SUM_W-1:0]    sum_q;
  logic                sat_q;
  logic [COUNT_W-1:0]  count_q;

  logic                out_valid_q;
  logic [SUM_W-1:0]    out_total_q;
  logic                out_sat_q;
  logic [COUNT_W-1:0]  out_count_q;

  step_info_t          iss_info;
  step_info_t          acc_info;
  logic [H-1:0]        mul_a, mul_b;
  logic                mul_neg;
  logic [2*H-1:0]      mul_p;
  logic [RW-1:0]       cacc_base;
  logic [RW-1:0]       cacc_d;
  logic [LW-1:0]       len_term;

  logic [AW-1:0]       tot;
  logic                over;
  logic [SUM_W-1:0]    sum_new;
  logic                sat_new;
  logic [COUNT_W-1:0]  count_new;

  logic                in_acc;
  logic                out_acc;
  logic                out_free;
  logic                issue;
  logic                mul_done;

  sqrt_ctrl_t          sq_ctrl;
  sqrt_stat_t          sq_stat;
  logic [RW-1:0]       root;

  // Transaction handshakes.
  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_acc  = out_valid_q & ~out_stall_i;
  assign out_free = ~out_valid_q | ~out_stall_i;

  // Edge vectors from vertex 0, kept as magnitude and sign.
  assign c0[0] = v0_x_i; assign c0[1] = v0_y_i; assign c0[2] = v0_z_i;
  assign c1[0] = v1_x_i; assign c1[1] = v1_y_i; assign c1[2] = v1_z_i;
  assign c2[0] = v2_x_i; assign c2[1] = v2_y_i; assign c2[2] = v2_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_diff[i]     = {c1[i][W-1], c1[i]} - {c0[i][W-1], c0[i]};
      e_diff[i + 3] = {c2[i][W-1], c2[i]} - {c0[i][W-1], c0[i]};
    end
    for (int i = 0; i < 6; i++) begin
      e_neg_d[i] = e_diff[i][W];
      e_mag_d[i] = e_diff[i][W] ? W'((~e_diff[i]) + {{W{1'b0}}, 1'b1}) : e_diff[i][W-1:0];
    end
  end

  // Operand selection for the shared multiplier.
  assign iss_info = step_info(step_q);
  assign acc_info = step_info(pstep_q);
  assign issue    = (state_q == ST_MUL) && (step_q != STEP_END);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    if (iss_info.is_cross) begin
      mul_a   = {1'b0, e_mag_q[iss_info.op_a]};
      mul_b   = {1'b0, e_mag_q[iss_info.op_b]};
      mul_neg = e_neg_q[iss_info.op_a] ^ e_neg_q[iss_info.op_b];
    end else begin
      case (iss_info.kind)
        KIND_HH: begin
          mul_a = cm_q[iss_info.axis][RW-1:H];
          mul_b = cm_q[iss_info.axis][RW-1:H];
        end
        KIND_HL: begin
          mul_a = cm_q[iss_info.axis][RW-1:H];
          mul_b = cm_q[iss_info.axis][H-1:0];
        end
        KIND_LL: begin
          mul_a = cm_q[iss_info.axis][H-1:0];
          mul_b = cm_q[iss_info.axis][H-1:0];
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
    mul_p = mul_a * mul_b;
  end

  // Accumulation of the registered product into a cross term or the squared length.
  always_comb begin
    cacc_base = acc_info.odd ? cacc_q : '0;
    cacc_d    = (pneg_q ^ acc_info.odd) ? (cacc_base - prod_q) : (cacc_base + prod_q);
    case (acc_info.kind)
      KIND_HH: len_term = {prod_q, {(2 * H){1'b0}}};
      KIND_HL: len_term = LW'({prod_q, {(H + 1){1'b0}}});
      KIND_LL: len_term = LW'(prod_q);
      default: len_term = '0;
    endcase
  end

  assign mul_done = pvld_q && (pstep_q == LAST_STEP);

  // Saturating sum and face count for the finished face.
  always_comb begin
    tot       = AW'(sum_q) + AW'(root);
    over      = |tot[AW-1:SUM_W];
    sum_new   = over ? SUM_MAX : tot[SUM_W-1:0];
    sat_new   = sat_q | over;
    count_new = (count_q == COUNT_MAX) ? count_q : count_q + 1'b1;
  end

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    sq_ctrl.start = 1'b0;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_MUL;
      ST_MUL:   if (mul_done) state_d = ST_RGO;
      ST_RGO: begin
        sq_ctrl.start = 1'b1;
        state_d       = ST_RWAIT;
      end
      ST_RWAIT: if (sq_stat.done) state_d = ST_ACC;
      ST_ACC:   if (!last_q || out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      pstep_q    <= '0;
      pvld_q     <= 1'b0;
      abs_pend_q <= 1'b0;
      abs_axis_q <= AXIS_X;
    end else begin
      state_q <= state_d;
      pvld_q  <= issue;
      if (in_acc) begin
        step_q <= '0;
      end else if (issue) begin
        step_q  <= step_q + 1'b1;
        pstep_q <= step_q;
      end
      abs_pend_q <= pvld_q & acc_info.is_cross & acc_info.odd;
      if (pvld_q) begin
        abs_axis_q <= acc_info.axis;
      end
    end
  end

  // Datapath registers of the current face.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < 6; i++) begin
        e_mag_q[i] <= e_mag_d[i];
        e_neg_q[i] <= e_neg_d[i];
      end
      last_q <= last_face_i;
      len_q  <= '0;
    end else if (pvld_q && !acc_info.is_cross) begin
      len_q <= len_q + len_term;
    end
    if (issue) begin
      prod_q <= mul_p;
      pneg_q <= mul_neg;
    end
    if (pvld_q && acc_info.is_cross) begin
      cacc_q <= cacc_d;
    end
    if (abs_pend_q) begin
      cm_q[abs_axis_q] <= cacc_q[RW-1] ? ((~cacc_q) + {{(RW - 1){1'b0}}, 1'b1}) : cacc_q;
    end
  end

  // Running mesh state and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      sat_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_ACC) && last_q && out_free) begin
        out_valid_q <= 1'b1;
        sum_q       <= '0;
        sat_q       <= 1'b0;
        count_q     <= '0;
      end else begin
        if (out_acc) begin
          out_valid_q <= 1'b0;
        end
        if ((state_q == ST_ACC) && !last_q) begin
          sum_q   <= sum_new;
          sat_q   <= sat_new;
          count_q <= count_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_ACC) && last_q && out_free) begin
      out_total_q <= sum_new;
      out_sat_q   <= sat_new;
      out_count_q <= count_new;
    end
  end

  // Square-root unit.
  tmaa_sqrt #(
    .ROOT_W (RW)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (sq_ctrl),
    .radicand_i (len_q),
    .stat_o     (sq_stat),
    .root_o     (root)
  );

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign total_area_o = out_total_q;
  assign saturated_o  = out_sat_q;
  assign face_count_o = out_count_q;

endmodule

`default_nettype wire

FILE: src/tmaa_sqrt.sv
// Bit-serial floor square root, two radicand bits per cycle.
`default_nettype none

module tmaa_sqrt
  import tmaa_pkg::*;
#(
  parameter int unsigned ROOT_W = 50
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sqrt_ctrl_t            ctrl_i,
  input  wire logic [2*ROOT_W-1:0]   radicand_i,
  output sqrt_stat_t                 stat_o,
  output logic [ROOT_W-1:0]          root_o
);

  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] rad_q;
  logic [ROOT_W:0]     rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [ROOT_W+1:0]   rem_sh;
  logic [ROOT_W+2:0]   trial;
  logic                fits;

  // One restoring step: bring down two bits and try the next root bit.
  always_comb begin
    rem_sh = {rem_q[ROOT_W-1:0], rad_q[2*ROOT_W-1 -: 2]};
    trial  = {1'b0, rem_sh} - {1'b0, root_q, 2'b01};
    fits   = ~trial[ROOT_W+2];
  end

  // Iteration counter and status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Radicand, partial remainder and root.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*ROOT_W-3:0], 2'b00};
      rem_q  <= fits ? trial[ROOT_W:0] : rem_sh[ROOT_W:0];
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

`default_nettype wire

FILE: src/tmaa_checker.sv
// Port-level checks of the mesh area accumulator, bound to the top level.
`default_nettype none

module tmaa_checker
  import tmaa_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [SUM_W-1:0]    total_area_o,
  input wire logic                saturated_o,
  input wire logic [COUNT_W-1:0]  face_count_o
);

  // A stalled result transaction stays offered with the same payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(total_area_o)
      && $stable(saturated_o) && $stable(face_count_o))
    else $error("stalled result changed");

  // An accepted triangle keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a triangle");

  // Every reported mesh holds at least one face.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> face_count_o != '0)
    else $error("mesh result with zero faces");

  // A saturated total is pinned at its maximum.
  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> total_area_o == SUM_MAX)
    else $error("saturated total below maximum");

  // A new result only appears while a triangle is in work.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a triangle in work");

endmodule

bind triangle_mesh_area_accumulator tmaa_checker u_tmaa_checker (.*);

`default_nettype wire
